@@ src/tsd_pkg.sv @@
`timescale 1ns / 1ps

package tsd_pkg;

  // Default width of the octal size accumulator and of the remaining-byte counter.
  localparam int unsigned SIZE_BITS_DEF = 36;
  localparam int unsigned SIZE_BITS_MAX = 64;

  // Width of the size field on the result channel.
  localparam int unsigned OUT_SIZE_W = 36;

  // Depth of the queue between the parser and the output stage.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Result kinds.
  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_HDR   = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_END   = 3'd3;
  localparam logic [2:0] KIND_TRUNC = 3'd4;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       stream_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic [7:0]            data_byte;
    logic [OUT_SIZE_W-1:0] entry_size;
    logic [7:0]            entry_type;
    logic                  last_data;
  } out_item_t;

  // What one input byte leaves behind: an optional main result and an
  // optional truncation error that follows it.
  typedef struct packed {
    logic      has_main;
    out_item_t main;
    logic      add_trunc;
  } rec_t;

endpackage

@@ src/tar_stream_deframer.sv @@
`timescale 1ns / 1ps

// Tar archive deframer: splits a ustar byte stream into name bytes, header
// records, file data bytes and end/error markers.
// Input channel: drive in_item_i and raise push; a byte is taken on a clock
// edge where push is high and full is low; one byte per clock while not full.
// Result channel: while empty is low the oldest result sits on out_item_o;
// pulse pop to take it. Kinds: name byte, header complete (with size and type),
// data byte (last_data marks the final one), end of archive, truncation error.
// A result is written into the queue by the edge that takes its byte, then
// loaded into the output register, which drives out_item_o. Throughput is set
// by the single-byte parser: one byte per cycle, one result per cycle on the
// output side, while neither full nor a stalled receiver holds the flow. A byte
// can yield two results (a result plus a truncation error); the extra output
// slot is absorbed by the 4-entry queue.
// When the receiver stalls, results pile up in the queue; once it is full,
// full rises and input is held off. Nothing is dropped.
// Reset clears the parser to the header phase at offset zero, empties the
// queue and the output register. A byte marked stream_last also returns the
// parser to that state, ready for the next archive.
module tar_stream_deframer #(
  parameter int unsigned SIZE_BITS = tsd_pkg::SIZE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  tsd_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output tsd_pkg::out_item_t out_item_o
);

  logic          fq_push, fq_full, fq_empty, fq_pop;
  tsd_pkg::rec_t fq_rec_in, fq_rec_out;

  // Front: classify each byte and update the header/data/padding state.
  tsd_front #(
    .SIZE_BITS (SIZE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .q_full_i  (fq_full),
    .q_push_o  (fq_push),
    .q_rec_o   (fq_rec_in)
  );

  // Short queue so the parser and the output side stall independently.
  tsd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .rec_i   (fq_rec_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .rec_o   (fq_rec_out),
    .empty_o (fq_empty)
  );

  // Back: serialize each record into one or two results.
  tsd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (fq_empty),
    .q_rec_i    (fq_rec_out),
    .q_pop_o    (fq_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

  // Input stalls only on a full queue.
  assign full = fq_full;

endmodule

@@ src/tsd_front.sv @@
`timescale 1ns / 1ps

module tsd_front #(
  parameter int unsigned SIZE_BITS = tsd_pkg::SIZE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tsd_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output tsd_pkg::rec_t     q_rec_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_PAD    = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam logic [8:0] OFF_LAST  = 9'd511;
  localparam logic [8:0] NAME_LEN  = 9'd100;
  localparam logic [8:0] SIZE_OFF  = 9'd124;
  localparam logic [8:0] SIZE_END  = 9'd136;
  localparam logic [8:0] TYPE_OFF  = 9'd156;
  localparam logic [7:0] DIR_TYPE  = 8'h35;

  logic [1:0]           phase_q, phase_d;
  logic [8:0]           off_q, off_d;
  logic [SIZE_BITS-1:0] acc_q, acc_d;
  logic                 oct_stop_q, oct_stop_d;
  logic                 name_end_q, name_end_d;
  logic                 all_zero_q, all_zero_d;
  logic [7:0]           type_q, type_d;
  logic [SIZE_BITS-1:0] rem_q, rem_d;

  logic                 accept;
  logic [7:0]           b;
  logic [8:0]           off_inc;
  logic [63:0]          acc_ext;
  tsd_pkg::rec_t        rec;

  assign accept  = push_i && !q_full_i;
  assign b       = in_item_i.archive_byte;
  assign off_inc = off_q + 9'd1;
  assign acc_ext = 64'(acc_q);

  always_comb begin
    phase_d    = phase_q;
    off_d      = off_q;
    acc_d      = acc_q;
    oct_stop_d = oct_stop_q;
    name_end_d = name_end_q;
    all_zero_d = all_zero_q;
    type_d     = type_q;
    rem_d      = rem_q;
    rec        = '0;

    if (accept) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (off_q < NAME_LEN && !name_end_q) begin
            if (b == 8'd0) begin
              name_end_d = 1'b1;
            end else begin
              rec.has_main       = 1'b1;
              rec.main.kind      = tsd_pkg::KIND_NAME;
              rec.main.data_byte = b;
            end
          end
          if (off_q >= SIZE_OFF && off_q < SIZE_END && !oct_stop_q) begin
            if (b == 8'd0) begin
              oct_stop_d = 1'b1;
            end else if (b >= 8'h30 && b <= 8'h37) begin
              acc_d = {acc_q[SIZE_BITS-4:0], 3'b000} + SIZE_BITS'(b[2:0]);
            end
          end
          if (off_q == TYPE_OFF) begin
            type_d = b;
          end
          if (b != 8'd0) begin
            all_zero_d = 1'b0;
          end

          if (off_q == OFF_LAST) begin
            rec.has_main = 1'b1;
            if (all_zero_q && b == 8'd0) begin
              rec.main.kind = tsd_pkg::KIND_END;
              phase_d       = PH_DONE;
            end else begin
              rec.main.kind       = tsd_pkg::KIND_HDR;
              rec.main.entry_size = acc_ext[tsd_pkg::OUT_SIZE_W-1:0];
              rec.main.entry_type = type_q;
              if (type_q != DIR_TYPE && acc_q != '0) begin
                phase_d       = PH_DATA;
                rem_d         = acc_q;
                rec.add_trunc = in_item_i.stream_last;
              end
            end
            // Clear the header scratch for the next block.
            off_d      = '0;
            acc_d      = '0;
            oct_stop_d = 1'b0;
            name_end_d = 1'b0;
            all_zero_d = 1'b1;
            type_d     = '0;
          end else begin
            off_d         = off_inc;
            rec.add_trunc = in_item_i.stream_last;
          end
        end
        PH_DATA: begin
          rec.has_main       = 1'b1;
          rec.main.kind      = tsd_pkg::KIND_DATA;
          rec.main.data_byte = b;
          rec.main.last_data = (rem_q == SIZE_BITS'(1));
          rem_d              = rem_q - SIZE_BITS'(1);
          off_d              = off_inc;
          if (rem_q == SIZE_BITS'(1)) begin
            phase_d = (off_inc == 9'd0) ? PH_HEADER : PH_PAD;
          end else begin
            rec.add_trunc = in_item_i.stream_last;
          end
        end
        PH_PAD: begin
          off_d = off_inc;
          if (off_inc == 9'd0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          // Done: drop every byte.
        end
      endcase

      // Stream end: return to the reset state for a new archive.
      if (in_item_i.stream_last) begin
        phase_d    = PH_HEADER;
        off_d      = '0;
        acc_d      = '0;
        oct_stop_d = 1'b0;
        name_end_d = 1'b0;
        all_zero_d = 1'b1;
        type_d     = '0;
        rem_d      = '0;
      end
    end
  end

  assign q_push_o = accept && (rec.has_main || rec.add_trunc);
  assign q_rec_o  = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      off_q      <= '0;
      acc_q      <= '0;
      oct_stop_q <= 1'b0;
      name_end_q <= 1'b0;
      all_zero_q <= 1'b1;
      type_q     <= '0;
      rem_q      <= '0;
    end else begin
      phase_q    <= phase_d;
      off_q      <= off_d;
      acc_q      <= acc_d;
      oct_stop_q <= oct_stop_d;
      name_end_q <= name_end_d;
      all_zero_q <= all_zero_d;
      type_q     <= type_d;
      rem_q      <= rem_d;
    end
  end

  a_data_rem_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> rem_q != '0)
    else $error("data phase with no bytes remaining");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> !q_push_o)
    else $error("result produced after end of archive");

  a_pad_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAD |-> off_q != 9'd0)
    else $error("padding phase on a block boundary");

endmodule

@@ src/tsd_queue.sv @@
`timescale 1ns / 1ps

module tsd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tsd_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output tsd_pkg::rec_t rec_o,
  output logic          empty_o
);

  tsd_pkg::rec_t                   mem [tsd_pkg::QUEUE_DEPTH];
  logic [tsd_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [tsd_pkg::QPTR_W:0]        count_q;
  logic                            do_push, do_pop;

  assign full_o  = (count_q == (tsd_pkg::QPTR_W+1)'(tsd_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rec_o   = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (tsd_pkg::QPTR_W+1)'(tsd_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full_o && empty_o))
    else $error("queue full and empty at once");

endmodule

@@ src/tsd_back.sv @@
`timescale 1ns / 1ps

module tsd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  tsd_pkg::rec_t      q_rec_i,
  output logic               q_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output tsd_pkg::out_item_t out_item_o
);

  logic               main_pend_q, trunc_pend_q;
  tsd_pkg::out_item_t main_q;
  tsd_pkg::out_item_t trunc_item;
  logic               free, load, take;

  assign empty_o = !(main_pend_q || trunc_pend_q);
  assign take    = pop_i && !empty_o;
  // Free once the last pending result of the held record leaves.
  assign free    = empty_o || (take && !(main_pend_q && trunc_pend_q));
  assign load    = free && !q_empty_i;
  assign q_pop_o = load;

  always_comb begin
    trunc_item      = '0;
    trunc_item.kind = tsd_pkg::KIND_TRUNC;
  end

  assign out_item_o = main_pend_q ? main_q : trunc_item;

  always_ff @(posedge clk_i) begin
    if (load) begin
      main_q <= q_rec_i.main;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_pend_q  <= 1'b0;
      trunc_pend_q <= 1'b0;
    end else if (load) begin
      main_pend_q  <= q_rec_i.has_main;
      trunc_pend_q <= q_rec_i.add_trunc;
    end else if (take) begin
      if (main_pend_q) begin
        main_pend_q <= 1'b0;
      end else begin
        trunc_pend_q <= 1'b0;
      end
    end
  end

  a_trunc_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !main_pend_q) |-> out_item_o.kind == tsd_pkg::KIND_TRUNC)
    else $error("error slot carries a wrong kind");

  a_trunc_after_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && main_pend_q && trunc_pend_q) |=> (trunc_pend_q && !main_pend_q))
    else $error("truncation result lost behind main result");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)))
    else $error("waiting result changed while stalled");

endmodule
